@@ hdl/srfp_pkg.sv @@
// ---------------------------------------------------------------------------
// srfp_pkg
// Shared types and constants of the sample ring frame packer.
// ---------------------------------------------------------------------------
package srfp_pkg;

	// input function codes
	localparam logic [1:0] FUNC_PUSH    = 2'd0;
	localparam logic [1:0] FUNC_XMIT    = 2'd1;
	localparam logic [1:0] FUNC_RESTART = 2'd2;
	localparam logic [1:0] FUNC_NONE    = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_FRAME_N = 2'd0;
	localparam logic [1:0] CFG_MAGIC   = 2'd1;
	localparam logic [1:0] CFG_VERSION = 2'd2;

	// full scale of the sawtooth test value
	localparam int RAMP_TOP = 4095;

	// largest frame size that a transmit honors
	localparam int MAX_PER_FRAME = 16;

	// lead flag bit positions
	localparam int LEAD_P_BIT = 0;
	localparam int LEAD_M_BIT = 1;

	// configuration register set
	typedef struct packed {
		logic [4:0] frame_n;
		logic [7:0] magic;
		logic [7:0] version;
	} cfg_t;

	// classified command passed from front to back
	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] sample;
		logic [1:0]  leads;
		logic [11:0] ramp;
	} cmd_t;

	// one timepoint as held in the ring
	typedef struct packed {
		logic [1:0]  leads;
		logic [11:0] ramp;
		logic [15:0] sample;
	} tp_t;

	// one result item
	typedef struct packed {
		logic        is_header;
		logic        last;
		logic [7:0]  magic_byte;
		logic [7:0]  version_byte;
		logic [15:0] sequence_res;
		logic [4:0]  count;
		logic [1:0]  lead_flags;
		logic [15:0] channel0;
		logic [11:0] channel1;
	} res_t;

endpackage

@@ hdl/srfp_cmd_fifo.sv @@
// ---------------------------------------------------------------------------
// srfp_cmd_fifo
// Two-entry command queue between the front and the back.
// ---------------------------------------------------------------------------
module srfp_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  srfp_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          rd_en,
	output srfp_pkg::cmd_t rd_cmd,
	output logic          empty
);
	import srfp_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_wr;
	logic       do_rd;

	assign full   = (cnt_q == 2'd2);
	assign empty  = (cnt_q == 2'd0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_cmd = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) wr_ptr_q <= ~wr_ptr_q;
			if (do_rd) rd_ptr_q <= ~rd_ptr_q;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 2'd1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 2'd1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) slot_q[wr_ptr_q] <= wr_cmd;
	end

endmodule

@@ hdl/srfp_front.sv @@
// ---------------------------------------------------------------------------
// srfp_front
// Accepts input transactions, classifies them and attaches the sawtooth
// test value to each push.
// ---------------------------------------------------------------------------
module srfp_front #(
	parameter int RAMP_PERIOD = 500
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  logic [1:0]     func,
	input  logic signed [15:0] sample,
	input  logic           lead_plus,
	input  logic           lead_minus,
	input  logic           fifo_full,
	output logic           enq,
	output srfp_pkg::cmd_t enq_cmd
);
	import srfp_pkg::*;

	localparam int IW       = (RAMP_PERIOD > 2) ? $clog2(RAMP_PERIOD) : 1;
	localparam int RAMP_DEN = RAMP_PERIOD - 1;
	localparam int STEP_Q   = RAMP_TOP / RAMP_DEN;
	localparam int STEP_R   = RAMP_TOP % RAMP_DEN;

	logic [IW-1:0] ramp_idx_q;
	logic [11:0]   ramp_q;
	logic [11:0]   ramp_rem_q;
	logic [12:0]   rem_sum;
	logic          rem_over;
	logic          accept;
	logic          is_push;

	assign full    = fifo_full;
	assign accept  = push && !fifo_full;
	assign is_push = accept && (func == FUNC_PUSH);

	// classify: unknown function is dropped at the door
	always_comb begin
		unique case (func)
			FUNC_PUSH, FUNC_XMIT, FUNC_RESTART: enq = accept;
			default: enq = 1'b0;
		endcase
	end

	always_comb begin
		enq_cmd.func   = func;
		enq_cmd.sample = sample;
		enq_cmd.leads  = {lead_minus, lead_plus};
		enq_cmd.ramp   = ramp_q;
	end

	// ramp step as quotient plus remainder, one compare and subtract
	assign rem_sum  = {1'b0, ramp_rem_q} + 13'(STEP_R);
	assign rem_over = (rem_sum >= 13'(RAMP_DEN));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_idx_q <= '0;
			ramp_q     <= '0;
			ramp_rem_q <= '0;
		end else if (is_push) begin
			if (ramp_idx_q == IW'(RAMP_PERIOD - 1)) begin
				ramp_idx_q <= '0;
				ramp_q     <= '0;
				ramp_rem_q <= '0;
			end else begin
				ramp_idx_q <= ramp_idx_q + IW'(1);
				if (rem_over) begin
					ramp_q     <= ramp_q + 12'(STEP_Q + 1);
					ramp_rem_q <= 12'(rem_sum - 13'(RAMP_DEN));
				end else begin
					ramp_q     <= ramp_q + 12'(STEP_Q);
					ramp_rem_q <= rem_sum[11:0];
				end
			end
		end
	end

endmodule

@@ hdl/srfp_back.sv @@
// ---------------------------------------------------------------------------
// srfp_back
// Executes queued commands against the timepoint ring and streams frames
// into the result register.
// ---------------------------------------------------------------------------
module srfp_back #(
	parameter int RING_DEPTH = 512
) (
	input  logic           clk,
	input  logic           arst_n,
	input  srfp_pkg::cfg_t cfg,
	input  logic           fifo_empty,
	input  srfp_pkg::cmd_t cmd,
	output logic           deq,
	input  logic           pop,
	output logic           empty,
	output srfp_pkg::res_t res
);
	import srfp_pkg::*;

	localparam int AW = (RING_DEPTH > 2) ? $clog2(RING_DEPTH) : 1;
	localparam int HW = $clog2(RING_DEPTH + 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN_W = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_HDR    = 3'd3;
	localparam logic [2:0] ST_TP_W   = 3'd4;
	localparam logic [2:0] ST_TP     = 3'd5;

	tp_t           ring_mem [RING_DEPTH];
	tp_t           ring_rdata_q;
	logic [2:0]    state_q;
	logic [AW-1:0] wr_idx_q;
	logic [AW-1:0] rd_idx_q;
	logic [HW-1:0] held_q;
	logic [15:0]   seq_q;
	logic [AW-1:0] scan_q;
	logic [4:0]    cnt_q;
	logic [1:0]    or_q;
	logic          out_valid_q;
	res_t          res_q;

	logic [4:0]    n_w;
	logic          held_ok;
	logic          ring_full;
	logic          ring_we;
	logic          slot_free;
	logic          load_hdr;
	logic          load_tp;
	logic          cnt_done;
	logic [AW-1:0] scan_nxt;

	function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
		logic [AW-1:0] r;
		if (p == AW'(RING_DEPTH - 1)) r = '0;
		else r = p + AW'(1);
		return r;
	endfunction

	// frame size with zero and oversize folded in
	always_comb begin
		if (cfg.frame_n == 5'd0) n_w = 5'd1;
		else if (32'(cfg.frame_n) > MAX_PER_FRAME) n_w = 5'(MAX_PER_FRAME);
		else n_w = cfg.frame_n;
	end

	assign held_ok   = (32'(held_q) >= 32'(n_w));
	assign ring_full = (held_q == HW'(RING_DEPTH));
	assign deq       = (state_q == ST_IDLE) && !fifo_empty;
	assign ring_we   = deq && (cmd.func == FUNC_PUSH);
	assign slot_free = !out_valid_q || pop;
	assign load_hdr  = (state_q == ST_HDR) && slot_free;
	assign load_tp   = (state_q == ST_TP) && slot_free;
	assign cnt_done  = (5'(cnt_q + 5'd1) == n_w);
	assign scan_nxt  = ring_inc(scan_q);
	assign empty     = !out_valid_q;
	assign res       = res_q;

	// ring memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (ring_we) ring_mem[wr_idx_q] <= tp_t'({cmd.leads, cmd.ramp, cmd.sample});
		ring_rdata_q <= ring_mem[scan_q];
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			held_q   <= '0;
			seq_q    <= '0;
			scan_q   <= '0;
			cnt_q    <= '0;
			or_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (deq) begin
						case (cmd.func)
							FUNC_PUSH: begin
								wr_idx_q <= ring_inc(wr_idx_q);
								if (ring_full) rd_idx_q <= ring_inc(rd_idx_q);
								else held_q <= held_q + HW'(1);
							end
							FUNC_XMIT: begin
								if (held_ok) begin
									scan_q  <= rd_idx_q;
									cnt_q   <= '0;
									or_q    <= '0;
									state_q <= ST_SCAN_W;
								end
							end
							FUNC_RESTART: begin
								wr_idx_q <= '0;
								rd_idx_q <= '0;
								held_q   <= '0;
								seq_q    <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN_W: state_q <= ST_SCAN;
				ST_SCAN: begin
					or_q <= or_q | ring_rdata_q.leads;
					if (cnt_done) begin
						scan_q  <= rd_idx_q;
						cnt_q   <= '0;
						state_q <= ST_HDR;
					end else begin
						scan_q  <= scan_nxt;
						cnt_q   <= cnt_q + 5'd1;
						state_q <= ST_SCAN_W;
					end
				end
				ST_HDR: begin
					if (slot_free) state_q <= ST_TP_W;
				end
				ST_TP_W: state_q <= ST_TP;
				ST_TP: begin
					if (slot_free) begin
						scan_q <= scan_nxt;
						cnt_q  <= cnt_q + 5'd1;
						if (cnt_done) begin
							rd_idx_q <= scan_nxt;
							held_q   <= held_q - HW'(n_w);
							seq_q    <= seq_q + 16'd1;
							state_q  <= ST_IDLE;
						end else begin
							state_q <= ST_TP_W;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (load_hdr || load_tp) out_valid_q <= 1'b1;
		else if (pop) out_valid_q <= 1'b0;
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (load_hdr) begin
			res_q.is_header    <= 1'b1;
			res_q.last         <= 1'b0;
			res_q.magic_byte   <= cfg.magic;
			res_q.version_byte <= cfg.version;
			res_q.sequence_res <= seq_q;
			res_q.count        <= n_w;
			res_q.lead_flags   <= or_q;
			res_q.channel0     <= '0;
			res_q.channel1     <= '0;
		end else if (load_tp) begin
			res_q.is_header    <= 1'b0;
			res_q.last         <= cnt_done;
			res_q.magic_byte   <= '0;
			res_q.version_byte <= '0;
			res_q.sequence_res <= seq_q;
			res_q.count        <= '0;
			res_q.lead_flags   <= ring_rdata_q.leads;
			res_q.channel0     <= ring_rdata_q.sample;
			res_q.channel1     <= ring_rdata_q.ramp;
		end
	end

endmodule

@@ hdl/sample_ring_frame_packer.sv @@
// ---------------------------------------------------------------------------
// sample_ring_frame_packer
// Collects ECG timepoints into a drop-oldest ring and packs them into frames.
// ---------------------------------------------------------------------------
// A push transaction stores one timepoint (sample, sawtooth test value, lead
// bits) and produces no result; it passes through the command queue into the
// ring. A transmit with at least the frame size held (frame_n, zero taken as
// one, clamped to 16) produces a header followed by that many timepoint
// results. The ring has one read port, so the block reads the frame twice,
// once to gather the lead flags for the header and once to stream the
// timepoints. A transmit with too few held and a restart produce no result.
// A two-entry command queue lets new transactions be accepted while a frame
// is still streaming out, and the result register holds a finished result
// while the next one is prepared. Configuration writes are always ready.
// There is no clearing pass after reset.
module sample_ring_frame_packer #(
	parameter int RING_DEPTH  = 512,
	parameter int RAMP_PERIOD = 500
) (
	input  logic               clk,
	input  logic               arst_n,
	// input queue side
	input  logic               push,
	output logic               full,
	input  logic [1:0]         func,
	input  logic signed [15:0] sample,
	input  logic               lead_plus,
	input  logic               lead_minus,
	// result queue side
	output logic               empty,
	input  logic               pop,
	output logic               is_header,
	output logic               last,
	output logic [7:0]         magic_byte,
	output logic [7:0]         version_byte,
	output logic [15:0]        sequence_res,
	output logic [4:0]         count,
	output logic [1:0]         lead_flags,
	output logic signed [15:0] channel0,
	output logic [11:0]        channel1,
	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);
	import srfp_pkg::*;

	cfg_t cfg_q;
	cmd_t enq_cmd;
	cmd_t deq_cmd;
	res_t res;
	logic enq;
	logic deq;
	logic fifo_full;
	logic fifo_empty;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_n <= 5'd1;
			cfg_q.magic   <= 8'd0;
			cfg_q.version <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FRAME_N: cfg_q.frame_n <= cfg_data[4:0];
				CFG_MAGIC:   cfg_q.magic   <= cfg_data;
				CFG_VERSION: cfg_q.version <= cfg_data;
				default: ;
			endcase
		end
	end

	srfp_front #(
		.RAMP_PERIOD(RAMP_PERIOD)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.func      (func),
		.sample    (sample),
		.lead_plus (lead_plus),
		.lead_minus(lead_minus),
		.fifo_full (fifo_full),
		.enq       (enq),
		.enq_cmd   (enq_cmd)
	);

	srfp_cmd_fifo u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.wr_en (enq),
		.wr_cmd(enq_cmd),
		.full  (fifo_full),
		.rd_en (deq),
		.rd_cmd(deq_cmd),
		.empty (fifo_empty)
	);

	srfp_back #(
		.RING_DEPTH(RING_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.fifo_empty(fifo_empty),
		.cmd       (deq_cmd),
		.deq       (deq),
		.pop       (pop),
		.empty     (empty),
		.res       (res)
	);

	// result fields
	assign is_header    = res.is_header;
	assign last         = res.last;
	assign magic_byte   = res.magic_byte;
	assign version_byte = res.version_byte;
	assign sequence_res = res.sequence_res;
	assign count        = res.count;
	assign lead_flags   = res.lead_flags;
	assign channel0     = res.channel0;
	assign channel1     = res.channel1;

endmodule

@@ tb/sv/srfp_checker.sv @@
// ---------------------------------------------------------------------------
// srfp_checker
// Predicts and checks the frames of the sample ring frame packer.
// ---------------------------------------------------------------------------
// Watches the configuration, input and result channels of the block. Every
// accepted input transaction is run through a cycle-free model of the ring,
// the sawtooth and the framing rules. The frames that it yields are queued
// in order. Every accepted result is compared field by field against the
// oldest queued result. The number of results still due and the number of
// mismatches are handed to the testbench top.
module srfp_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic [1:0]         func,
	input  logic signed [15:0] sample,
	input  logic               lead_plus,
	input  logic               lead_minus,
	input  logic               empty,
	input  logic               pop,
	input  logic               is_header,
	input  logic               last,
	input  logic [7:0]         magic_byte,
	input  logic [7:0]         version_byte,
	input  logic [15:0]        sequence_res,
	input  logic [4:0]         count,
	input  logic [1:0]         lead_flags,
	input  logic signed [15:0] channel0,
	input  logic [11:0]        channel1,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	output int                 fail_count,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import srfp_pkg::*;

	localparam int RING_DEPTH  = 512;
	localparam int RAMP_PERIOD = 500;
	localparam int PTR_W       = $clog2(RING_DEPTH);

	// model state
	tp_t              ring [RING_DEPTH];
	logic [PTR_W-1:0] wr_ptr;
	logic [PTR_W-1:0] rd_ptr;
	logic [PTR_W:0]   held;
	logic [15:0]      model_seq;
	logic [8:0]       ramp_idx;
	cfg_t             cfg;
	res_t             results_due [$];
	res_t             got;
	res_t             want;

	// one line per mismatch
	task automatic report_mismatch(string msg);
		$display("%0t ns srfp_checker: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic check_field(string name, logic [31:0] seen, logic [31:0] due);
		if (seen !== due) begin
			report_mismatch($sformatf("%s got %0h expected %0h (frame seq %0h)",
				name, seen, due, want.sequence_res));
		end
	endtask

	// advance the model by one input transaction, queue the frame it yields
	task automatic predict_frame_results(logic [1:0] op, logic [15:0] smp,
		logic [1:0] leads);
		tp_t  tp;
		res_t hdr;
		res_t item;
		res_t body [$];
		int   n;
		case (op)
			FUNC_PUSH: begin
				tp.sample = smp;
				tp.leads  = leads;
				tp.ramp   = 12'((int'(ramp_idx) * RAMP_TOP) / (RAMP_PERIOD - 1));
				ramp_idx  = (ramp_idx == 9'(RAMP_PERIOD - 1)) ? '0 : ramp_idx + 1'b1;
				// drop the oldest when the ring is full
				if (int'(held) >= RING_DEPTH) begin
					rd_ptr++;
					held--;
				end
				ring[wr_ptr] = tp;
				wr_ptr++;
				held++;
			end
			FUNC_XMIT: begin
				// zero means one, oversize is clamped
				if (cfg.frame_n == 0)
					n = 1;
				else if (int'(cfg.frame_n) > MAX_PER_FRAME)
					n = MAX_PER_FRAME;
				else
					n = int'(cfg.frame_n);
				// too few held: nothing happens
				if (int'(held) >= n) begin
					hdr              = '0;
					hdr.is_header    = 1'b1;
					hdr.magic_byte   = cfg.magic;
					hdr.version_byte = cfg.version;
					hdr.sequence_res = model_seq;
					hdr.count        = 5'(n);
					for (int i = 0; i < n; i++) begin
						tp                = ring[rd_ptr];
						rd_ptr++;
						held--;
						item              = '0;
						item.last         = (i == n - 1);
						item.sequence_res = model_seq;
						item.lead_flags   = tp.leads;
						item.channel0     = tp.sample;
						item.channel1     = tp.ramp;
						hdr.lead_flags    = hdr.lead_flags | tp.leads;
						body.push_back(item);
					end
					results_due.push_back(hdr);
					foreach (body[i])
						results_due.push_back(body[i]);
					model_seq++;
				end
			end
			FUNC_RESTART: begin
				// ramp index and registers survive a restart
				wr_ptr    = '0;
				rd_ptr    = '0;
				held      = '0;
				model_seq = '0;
			end
			default: begin
				// unknown function is ignored
			end
		endcase
	endtask

	// sample all channels at the clock edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr      = '0;
			rd_ptr      = '0;
			held        = '0;
			model_seq   = '0;
			ramp_idx    = '0;
			cfg.frame_n = 5'd1;
			cfg.magic   = '0;
			cfg.version = '0;
			results_due.delete();
			fail_count  = 0;
			pending    <= 0;
		end else begin
			// register write transaction
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FRAME_N: cfg.frame_n = cfg_data[4:0];
					CFG_MAGIC:   cfg.magic   = cfg_data;
					CFG_VERSION: cfg.version = cfg_data;
					default:     ;
				endcase
			end

			// result transaction against the oldest expectation
			if (pop && !empty) begin
				got = {is_header, last, magic_byte, version_byte, sequence_res, count,
					lead_flags, channel0, channel1};
				if (results_due.size() == 0) begin
					report_mismatch($sformatf("result %h with no frame due", got));
				end else begin
					want = results_due.pop_front();
					check_field("is_header", got.is_header, want.is_header);
					check_field("last", got.last, want.last);
					check_field("magic_byte", got.magic_byte, want.magic_byte);
					check_field("version_byte", got.version_byte, want.version_byte);
					check_field("sequence_res", got.sequence_res, want.sequence_res);
					check_field("count", got.count, want.count);
					check_field("lead_flags", got.lead_flags, want.lead_flags);
					check_field("channel0", got.channel0, want.channel0);
					check_field("channel1", got.channel1, want.channel1);
				end
			end

			// input transaction, lead bit 0 is plus, bit 1 is minus
			if (push && !full)
				predict_frame_results(func, sample, {lead_minus, lead_plus});

			pending <= results_due.size();
		end
	end

endmodule

@@ tb/sv/tb_sample_ring_frame_packer.sv @@
// ---------------------------------------------------------------------------
// tb_sample_ring_frame_packer
// Stimulus and verdict for the sample ring frame packer.
// ---------------------------------------------------------------------------
// Drives a directed opening (field extremes, empty and short transmits,
// unknown function, restart, zero frame size), then random phases under
// several register settings and a closing run of one timepoint frames.
// Both sides idle in random bursts until the closing run. A separate checker
// predicts and compares.
module tb_sample_ring_frame_packer;
	timeunit 1ns;
	timeprecision 1ps;

	import srfp_pkg::*;

	localparam logic [1:0] CFG_UNUSED   = 2'd3;
	localparam int         DRAIN_CYCLES = 150;
	localparam int         CYCLE_LIMIT  = 2_000_000;
	localparam int         PHASE_ITEMS  = 75;
	localparam int         FINAL_FRAMES = 30;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               push       = 1'b0;
	logic [1:0]         func       = FUNC_PUSH;
	logic signed [15:0] sample     = '0;
	logic               lead_plus  = 1'b0;
	logic               lead_minus = 1'b0;
	logic               pop        = 1'b0;
	logic               cfg_valid  = 1'b0;
	logic [1:0]         cfg_index  = CFG_FRAME_N;
	logic [7:0]         cfg_data   = '0;
	logic               full;
	logic               empty;
	logic               is_header;
	logic               last;
	logic [7:0]         magic_byte;
	logic [7:0]         version_byte;
	logic [15:0]        sequence_res;
	logic [4:0]         count;
	logic [1:0]         lead_flags;
	logic signed [15:0] channel0;
	logic [11:0]        channel1;
	logic               cfg_ready;

	int                 fail_count;
	int                 pending;
	logic               quiet      = 1'b0;
	int                 stall_left = 0;
	int unsigned        cycles     = 0;
	logic [7:0]         size_codes [4] = '{8'h1F, 8'h02, 8'h10, 8'h00};

	sample_ring_frame_packer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.func         (func),
		.sample       (sample),
		.lead_plus    (lead_plus),
		.lead_minus   (lead_minus),
		.empty        (empty),
		.pop          (pop),
		.is_header    (is_header),
		.last         (last),
		.magic_byte   (magic_byte),
		.version_byte (version_byte),
		.sequence_res (sequence_res),
		.count        (count),
		.lead_flags   (lead_flags),
		.channel0     (channel0),
		.channel1     (channel1),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	srfp_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.func         (func),
		.sample       (sample),
		.lead_plus    (lead_plus),
		.lead_minus   (lead_minus),
		.empty        (empty),
		.pop          (pop),
		.is_header    (is_header),
		.last         (last),
		.magic_byte   (magic_byte),
		.version_byte (version_byte),
		.sequence_res (sequence_res),
		.count        (count),
		.lead_flags   (lead_flags),
		.channel0     (channel0),
		.channel1     (channel1),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("cycle limit reached, %0d results still due", pending);
			$display("tb_sample_ring_frame_packer: FAIL");
			$finish;
		end
	end

	// result side with random stall bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (stall_left > 0) begin
			pop        <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			pop        <= 1'b0;
			stall_left <= $urandom_range(0, 13);
		end else begin
			pop <= 1'b1;
		end
	end

	// one input transaction, with an optional idle burst ahead of it
	task automatic send_item(logic [1:0] f, logic [15:0] s, logic lp, logic lm);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 14);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push       <= 1'b1;
		func       <= f;
		sample     <= s;
		lead_plus  <= lp;
		lead_minus <= lm;
		do @(posedge clk); while (full);
	endtask

	task automatic send_random_push();
		send_item(FUNC_PUSH, 16'($urandom), 1'($urandom), 1'($urandom));
	endtask

	// wait until every frame is out and the block has settled
	task automatic drain();
		push <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// new register setting while the block is idle
	task automatic set_config(logic [7:0] size_code, logic [7:0] magic, logic [7:0] version);
		drain();
		cfg_write(CFG_FRAME_N, size_code);
		cfg_write(CFG_MAGIC, magic);
		cfg_write(CFG_VERSION, version);
		cfg_write(CFG_UNUSED, 8'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// mostly push bursts closed by a transmit, some single random items
	task automatic run_random(int n_items);
		int sent;
		int k;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 99) < 85) begin
				k = $urandom_range(1, 18);
				repeat (k) send_random_push();
				send_item(FUNC_XMIT, 16'($urandom), 1'($urandom), 1'($urandom));
				sent += k + 1;
			end else begin
				send_item(2'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: empty transmit, unknown function, extremes
		send_item(FUNC_XMIT, 16'h0000, 1'b0, 1'b0);
		send_item(FUNC_NONE, 16'h7FFF, 1'b1, 1'b1);
		send_item(FUNC_PUSH, 16'h7FFF, 1'b1, 1'b0);
		send_item(FUNC_PUSH, 16'h8000, 1'b0, 1'b1);
		send_item(FUNC_PUSH, 16'h0000, 1'b1, 1'b1);
		send_item(FUNC_PUSH, 16'hFFFF, 1'b0, 1'b0);
		repeat (4) send_item(FUNC_XMIT, 16'hFFFF, 1'b1, 1'b1);
		send_item(FUNC_XMIT, 16'h0000, 1'b0, 1'b0);
		send_item(FUNC_PUSH, 16'h1234, 1'b1, 1'b0);
		// restart then a transmit with nothing held
		send_item(FUNC_RESTART, 16'h0000, 1'b0, 1'b0);
		send_item(FUNC_XMIT, 16'h0000, 1'b0, 1'b0);

		// frame size zero acts as one, all-ones header bytes
		set_config(8'hE0, 8'hFF, 8'hFF);
		send_item(FUNC_PUSH, 16'h5555, 1'b1, 1'b1);
		send_item(FUNC_PUSH, 16'hAAAA, 1'b0, 1'b1);
		send_item(FUNC_XMIT, 16'h0000, 1'b0, 1'b0);
		send_item(FUNC_XMIT, 16'h0000, 1'b0, 1'b0);
		send_item(FUNC_XMIT, 16'h0000, 1'b0, 1'b0);

		// random phases, first one with an oversize frame setting
		for (int p = 0; p < 5; p++) begin
			set_config((p < 4) ? size_codes[p] : 8'($urandom), 8'($urandom), 8'($urandom));
			run_random(PHASE_ITEMS);
		end

		// no idling from here: one timepoint frames
		quiet <= 1'b1;
		set_config(8'hC1, 8'($urandom), 8'($urandom));
		repeat (FINAL_FRAMES) begin
			send_random_push();
			send_item(FUNC_XMIT, 16'($urandom), 1'($urandom), 1'($urandom));
		end

		drain();
		if (fail_count == 0)
			$display("tb_sample_ring_frame_packer: PASS");
		else
			$display("tb_sample_ring_frame_packer: FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/srfp_pkg.sv
hdl/srfp_cmd_fifo.sv
hdl/srfp_front.sv
hdl/srfp_back.sv
hdl/sample_ring_frame_packer.sv
tb/sv/srfp_checker.sv
tb/sv/tb_sample_ring_frame_packer.sv
